/* src/gdda_pkg.sv */
// ----------------------------------------------------------------------------
// gdda_pkg: shared types and codes of the grid ray walker
// Request codes, face codes, the walker state type and the step status.
// ----------------------------------------------------------------------------
`default_nettype none

package gdda_pkg;

    // Request kinds carried on i_cmd.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Face codes: the direction of the last step of a walk.
    localparam logic [1:0] FACE_COL_NEG = 2'd0;
    localparam logic [1:0] FACE_COL_POS = 2'd1;
    localparam logic [1:0] FACE_ROW_NEG = 2'd2;
    localparam logic [1:0] FACE_ROW_POS = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Status of one proposed step from the step unit.
    typedef struct packed {
        logic [1:0] face;
        logic       outside;
    } t_step_ctl;

endpackage

`default_nettype wire

/* src/gdda_step.sv */
// ----------------------------------------------------------------------------
// gdda_step: one DDA step of the grid ray walker
// Picks the axis, adds the matching delta with saturation and moves the cell,
// flagging a step that would leave the map.
// ----------------------------------------------------------------------------
`default_nettype none

module gdda_step import gdda_pkg::*; #(
    parameter int MAP_COLS  = 64,
    parameter int MAP_ROWS  = 64,
    parameter int DIST_BITS = 32,
    parameter int COL_W     = 6,
    parameter int ROW_W     = 6
) (
    input  wire logic [COL_W-1:0]     i_col,
    input  wire logic [ROW_W-1:0]     i_row,
    input  wire logic [DIST_BITS-1:0] i_col_dist,
    input  wire logic [DIST_BITS-1:0] i_row_dist,
    input  wire logic [DIST_BITS-1:0] i_dcol,
    input  wire logic [DIST_BITS-1:0] i_drow,
    input  wire logic                 i_col_neg,
    input  wire logic                 i_row_neg,
    output logic      [COL_W-1:0]     o_col,
    output logic      [ROW_W-1:0]     o_row,
    output logic      [DIST_BITS-1:0] o_col_dist,
    output logic      [DIST_BITS-1:0] o_row_dist,
    output t_step_ctl                 o_ctl
);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);

    logic [DIST_BITS:0] sum;
    logic [DIST_BITS-1:0] sat_sum;
    logic col_axis;

    // Ties go along the rows.
    assign col_axis = i_col_dist < i_row_dist;

    always_comb begin
        if (col_axis) begin
            sum = {1'b0, i_col_dist} + {1'b0, i_dcol};
        end else begin
            sum = {1'b0, i_row_dist} + {1'b0, i_drow};
        end
        sat_sum = sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
    end

    always_comb begin
        o_col       = i_col;
        o_row       = i_row;
        o_col_dist  = i_col_dist;
        o_row_dist  = i_row_dist;
        o_ctl       = '0;
        if (col_axis) begin
            o_col_dist = sat_sum;
            if (i_col_neg) begin
                o_ctl.face    = FACE_COL_NEG;
                o_ctl.outside = (i_col == '0);
                o_col         = i_col - COL_W'(1);
            end else begin
                o_ctl.face    = FACE_COL_POS;
                o_ctl.outside = (i_col == COL_LAST);
                o_col         = i_col + COL_W'(1);
            end
        end else begin
            o_row_dist = sat_sum;
            if (i_row_neg) begin
                o_ctl.face    = FACE_ROW_NEG;
                o_ctl.outside = (i_row == '0);
                o_row         = i_row - ROW_W'(1);
            end else begin
                o_ctl.face    = FACE_ROW_POS;
                o_ctl.outside = (i_row == ROW_LAST);
                o_row         = i_row + ROW_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/grid_ray_dda_walk.sv */
// ----------------------------------------------------------------------------
// grid_ray_dda_walk: grid ray walker using digital differential analysis
// Holds a one-bit wall map and walks rays across it one cell per cycle.
// ----------------------------------------------------------------------------
// Usage. A request is taken at a rising edge where start is high and busy is
// low. A write request (i_cmd = 0) stores i_wall_bit into the map cell at
// (i_cell_col, i_cell_row) at that same edge and gives no result; writes to
// cells outside the map are dropped. A cast request (i_cmd = 1) starts a walk
// from the given cell with the given side and delta distances.
//
// Timing. The walk state sits in registers and the wall map in a synchronous
// memory with a registered read. Each cycle the step unit proposes the next
// cell and its address goes to the memory; the wall bit of that cell comes
// back together with the registered position, so the walker takes one map
// step per cycle. Busy is high while a cast walks and falls as the result
// appears, so the next request can be taken at the edge that ends the result
// cycle. A cast that starts off the map and any write keep busy low; the
// result of such a cast appears in the cycle after it was taken.
//
// Results. Each result sits on the o_ ports for exactly one cycle, marked by
// o_valid; the receiver cannot stall, so no result is ever held back.
// Reset returns the walker to idle and drops any pending result; the wall
// map is not cleared and its cells are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_ray_dda_walk import gdda_pkg::*; #(
    parameter int MAP_COLS  = 64,
    parameter int MAP_ROWS  = 64,
    parameter int DIST_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [5:0]  i_cell_col,
    input  wire logic [5:0]  i_cell_row,
    input  wire logic        i_wall_bit,
    input  wire logic        i_step_col_neg,
    input  wire logic        i_step_row_neg,
    input  wire logic [31:0] i_side_col_dist,
    input  wire logic [31:0] i_side_row_dist,
    input  wire logic [31:0] i_delta_col_dist,
    input  wire logic [31:0] i_delta_row_dist,
    output logic             o_valid,
    output logic      [5:0]  o_hit_col,
    output logic      [5:0]  o_hit_row,
    output logic      [1:0]  o_face,
    output logic      [31:0] o_final_col_dist,
    output logic      [31:0] o_final_row_dist,
    output logic             o_off_grid
);

    // Walk coordinates are at least as wide as the request fields so that a
    // start cell outside a small map can still be told apart.
    localparam int COL_W  = ($clog2(MAP_COLS) > 6) ? $clog2(MAP_COLS) : 6;
    localparam int ROW_W  = ($clog2(MAP_ROWS) > 6) ? $clog2(MAP_ROWS) : 6;
    localparam int DEPTH  = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAP_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAP_ROWS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [COL_W-1:0]      r_col, n_col;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [DIST_BITS-1:0]  r_col_dist, n_col_dist;
    logic [DIST_BITS-1:0]  r_row_dist, n_row_dist;
    logic [DIST_BITS-1:0]  r_dcol, n_dcol;
    logic [DIST_BITS-1:0]  r_drow, n_drow;
    logic                  r_col_neg, n_col_neg;
    logic                  r_row_neg, n_row_neg;
    logic [1:0]            r_face, n_face;
    // High when r_rd_bit holds the wall bit of the current cell. It is low
    // on the start cell, which is never tested.
    logic                  r_chk, n_chk;
    logic                  r_rd_bit;

    logic                  r_valid, n_valid;
    logic [COL_W-1:0]      r_out_col, n_out_col;
    logic [ROW_W-1:0]      r_out_row, n_out_row;
    logic [1:0]            r_out_face, n_out_face;
    logic [DIST_BITS-1:0]  r_out_col_dist, n_out_col_dist;
    logic [DIST_BITS-1:0]  r_out_row_dist, n_out_row_dist;
    logic                  r_out_off, n_out_off;

    logic                  mem [0:DEPTH-1];

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic                  req_take;
    logic                  req_cast;
    logic                  req_write;
    logic                  req_in_map;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DIST_BITS-1:0]  in_side_col;
    logic [DIST_BITS-1:0]  in_side_row;
    logic                  walking;

    assign req_take   = start && !busy;
    assign req_cast   = req_take && (i_cmd == CMD_CAST);
    assign req_write  = req_take && (i_cmd == CMD_WRITE);
    assign req_in_map = (COL_W'(i_cell_col) <= COL_LAST) &&
                        (ROW_W'(i_cell_row) <= ROW_LAST);
    assign wr_addr    = ADDR_W'(ADDR_W'(i_cell_row) * ADDR_W'(MAP_COLS)) +
                        ADDR_W'(i_cell_col);

    // Distances are cut or widened to DIST_BITS on the way in.
    assign in_side_col = DIST_BITS'(i_side_col_dist);
    assign in_side_row = DIST_BITS'(i_side_row_dist);

    // ------------------------------------------------------------------
    // Step unit
    // ------------------------------------------------------------------
    logic [COL_W-1:0]      st_col;
    logic [ROW_W-1:0]      st_row;
    logic [DIST_BITS-1:0]  st_col_dist;
    logic [DIST_BITS-1:0]  st_row_dist;
    t_step_ctl             st_ctl;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  hit;
    logic                  advance;
    logic                  finish;

    gdda_step #(
        .MAP_COLS  (MAP_COLS),
        .MAP_ROWS  (MAP_ROWS),
        .DIST_BITS (DIST_BITS),
        .COL_W     (COL_W),
        .ROW_W     (ROW_W)
    ) u_step (
        .i_col      (r_col),
        .i_row      (r_row),
        .i_col_dist (r_col_dist),
        .i_row_dist (r_row_dist),
        .i_dcol     (r_dcol),
        .i_drow     (r_drow),
        .i_col_neg  (r_col_neg),
        .i_row_neg  (r_row_neg),
        .o_col      (st_col),
        .o_row      (st_row),
        .o_col_dist (st_col_dist),
        .o_row_dist (st_row_dist),
        .o_ctl      (st_ctl)
    );

    assign rd_addr = ADDR_W'(ADDR_W'(st_row) * ADDR_W'(MAP_COLS)) + ADDR_W'(st_col);
    assign hit     = r_chk && r_rd_bit;
    assign advance = walking && !hit && !st_ctl.outside;
    assign finish  = walking && (hit || st_ctl.outside);

    // ------------------------------------------------------------------
    // Control state machine
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_cast && req_in_map) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy    = 1'b0;
        walking = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy    = 1'b0;
                walking = 1'b0;
            end
            ST_WALK: begin
                busy    = 1'b1;
                walking = 1'b1;
            end
            default: begin
                busy    = 1'b0;
                walking = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Walk datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_col_dist = r_col_dist;
        n_row_dist = r_row_dist;
        n_dcol     = r_dcol;
        n_drow     = r_drow;
        n_col_neg  = r_col_neg;
        n_row_neg  = r_row_neg;
        n_face     = r_face;
        n_chk      = r_chk;
        if (req_cast) begin
            n_col      = COL_W'(i_cell_col);
            n_row      = ROW_W'(i_cell_row);
            n_col_dist = in_side_col;
            n_row_dist = in_side_row;
            n_dcol     = DIST_BITS'(i_delta_col_dist);
            n_drow     = DIST_BITS'(i_delta_row_dist);
            n_col_neg  = i_step_col_neg;
            n_row_neg  = i_step_row_neg;
            n_face     = FACE_COL_NEG;
            n_chk      = 1'b0;
        end else if (advance) begin
            n_col      = st_col;
            n_row      = st_row;
            n_col_dist = st_col_dist;
            n_row_dist = st_row_dist;
            n_face     = st_ctl.face;
            n_chk      = 1'b1;
        end
    end

    // Result capture: a cast that starts off the map, a wall hit, or a step
    // that would leave the map.
    always_comb begin
        n_valid        = 1'b0;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_face     = r_out_face;
        n_out_col_dist = r_out_col_dist;
        n_out_row_dist = r_out_row_dist;
        n_out_off      = r_out_off;
        if (req_cast && !req_in_map) begin
            n_valid        = 1'b1;
            n_out_col      = COL_W'(i_cell_col);
            n_out_row      = ROW_W'(i_cell_row);
            n_out_face     = FACE_COL_NEG;
            n_out_col_dist = in_side_col;
            n_out_row_dist = in_side_row;
            n_out_off      = 1'b1;
        end else if (walking && hit) begin
            n_valid        = 1'b1;
            n_out_col      = r_col;
            n_out_row      = r_row;
            n_out_face     = r_face;
            n_out_col_dist = r_col_dist;
            n_out_row_dist = r_row_dist;
            n_out_off      = 1'b0;
        end else if (walking && st_ctl.outside) begin
            n_valid        = 1'b1;
            n_out_col      = r_col;
            n_out_row      = r_row;
            n_out_face     = st_ctl.face;
            n_out_col_dist = st_col_dist;
            n_out_row_dist = st_row_dist;
            n_out_off      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col          <= n_col;
        r_row          <= n_row;
        r_col_dist     <= n_col_dist;
        r_row_dist     <= n_row_dist;
        r_dcol         <= n_dcol;
        r_drow         <= n_drow;
        r_col_neg      <= n_col_neg;
        r_row_neg      <= n_row_neg;
        r_face         <= n_face;
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_face     <= n_out_face;
        r_out_col_dist <= n_out_col_dist;
        r_out_row_dist <= n_out_row_dist;
        r_out_off      <= n_out_off;
    end

    // ------------------------------------------------------------------
    // Wall map. Writes are only taken while idle and reads only happen
    // while walking, so a read never meets a write to the same cell.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (req_write && req_in_map) begin
            mem[wr_addr] <= i_wall_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rd_bit <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_valid          = r_valid;
    assign o_hit_col        = r_out_col[5:0];
    assign o_hit_row        = r_out_row[5:0];
    assign o_face           = r_out_face;
    assign o_final_col_dist = 32'(r_out_col_dist);
    assign o_final_row_dist = 32'(r_out_row_dist);
    assign o_off_grid       = r_out_off;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cast_starts_walk : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_cast && req_in_map) |=> (busy && !r_chk))
        else $error("cast on the map did not start a walk");

    a_walk_on_map : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walking |-> ((r_col <= COL_LAST) && (r_row <= ROW_LAST)))
        else $error("walk position left the map");

    a_one_axis_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walking && r_chk) |-> (($past(r_col) != r_col) != ($past(r_row) != r_row)))
        else $error("walk step did not move exactly one coordinate");

    a_dist_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (walking && r_chk) |->
            ((r_col_dist >= $past(r_col_dist)) && (r_row_dist >= $past(r_row_dist))))
        else $error("side distance decreased during a walk");

    a_result_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while the walker is busy");

endmodule

`default_nettype wire
